// ----- src/ssr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants of the stepper speed ramp
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int CFG_W     = 16;
  localparam int SPEED_W   = 32;
  localparam int PERIOD_W  = 20;
  localparam int STEP_W    = 32;
  localparam int COUNT_W   = 31;
  localparam int DIV_N_W   = 36;
  localparam int DIV_D_W   = 32;
  localparam int DIV_CNT_W = 6;
  localparam int SUM_W     = 40;

  localparam logic [PERIOD_W-1:0]  US_PER_SEC = 20'd1000000;
  localparam logic [DIV_CNT_W-1:0] INC_STEPS  = 6'd36;
  localparam logic [DIV_CNT_W-1:0] PER_STEPS  = 6'd20;

  localparam logic [1:0] CFG_MIN_SPEED = 2'd0;
  localparam logic [1:0] CFG_MAX_SPEED = 2'd1;
  localparam logic [1:0] CFG_ACCEL     = 2'd2;
  localparam logic [1:0] CFG_NONLIN    = 2'd3;

  localparam logic [CFG_W-1:0] MIN_SPEED_RST = 16'd400;
  localparam logic [CFG_W-1:0] MAX_SPEED_RST = 16'd10000;
  localparam logic [CFG_W-1:0] ACCEL_RST     = 16'd1;
  localparam logic [CFG_W-1:0] NONLIN_RST    = 16'd500;

  localparam logic [1:0] PHASE_ACCEL  = 2'd0;
  localparam logic [1:0] PHASE_CRUISE = 2'd1;
  localparam logic [1:0] PHASE_DECEL  = 2'd2;

  typedef enum logic [2:0] {
    KIND_START,
    KIND_EQUAL,
    KIND_ACCEL,
    KIND_END_ACCEL,
    KIND_DECEL,
    KIND_HOLD
  } kind_t;

  typedef enum logic {
    DIV_INC,
    DIV_PER
  } div_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     div_go;
    div_sel_t div_sel;
    logic     apply_inc;
    logic     apply_per;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_t kind_now;
    logic  div_done;
    logic  speed_pos;
  } ctrl_sts_t;

endpackage

// ----- src/stepper_speed_ramp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_speed_ramp
// Step-rate generator: speed and step period of a stepper move, tick by tick
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall): req_type 0 starts a move of
// move_steps steps, req_type 1 advances the ramp by one step. Each request
// word gives exactly one result word on the res channel (res_valid /
// res_stall) carrying step_period_us, current_speed and ramp_phase.
// Settings are written through cfg_valid / cfg_ready, cfg_index, cfg_data;
// cfg_ready is always high and writes belong in idle time.
// One word is worked at a time; req_stall is high from acceptance until the
// result is loaded into the output register, as res_valid rises. Work per
// word is set by the serial divider (one quotient bit a cycle): a start or an
// end-of-acceleration tick runs the 20-bit period division; an acceleration
// or deceleration tick runs the 36-bit increment division and then, if the
// new speed is positive, the period division; cruise or equal ticks run none.
// A new word can be taken while the previous result still waits; a stalled
// receiver holds the result and the block waits before loading the next one.
// Synchronous reset restores the default settings and clears the move state.
// ----------------------------------------------------------------------------
module stepper_speed_ramp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [ssr_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic                               req_type,
  input  logic signed [ssr_pkg::STEP_W-1:0]  move_steps,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [ssr_pkg::PERIOD_W-1:0]       step_period_us,
  output logic signed [ssr_pkg::SPEED_W-1:0] current_speed,
  output logic [1:0]                         ramp_phase
);

  ssr_pkg::ctrl_cmd_t cmd;
  ssr_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  ssr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssr_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_type       (req_type),
    .move_steps     (move_steps),
    .cmd            (cmd),
    .sts            (sts),
    .step_period_us (step_period_us),
    .current_speed  (current_speed),
    .ramp_phase     (ramp_phase)
  );

endmodule

// ----- src/ssr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_div
// Restoring serial divider, one quotient bit per cycle, step count per start
// ----------------------------------------------------------------------------
module ssr_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ssr_pkg::DIV_N_W-1:0]     dividend,
  input  logic [ssr_pkg::DIV_D_W-1:0]     divisor,
  input  logic [ssr_pkg::DIV_CNT_W-1:0]   steps,
  output logic                            done,
  output logic [ssr_pkg::DIV_N_W-1:0]     quotient
);

  logic                            busy;
  logic [ssr_pkg::DIV_CNT_W-1:0]   cnt;
  logic [ssr_pkg::DIV_D_W-1:0]     rem;
  logic [ssr_pkg::DIV_N_W-1:0]     dq;
  logic [ssr_pkg::DIV_D_W:0]       rem_sh;
  logic [ssr_pkg::DIV_D_W+1:0]     diff;
  logic                            fits;

  assign rem_sh   = {rem, dq[ssr_pkg::DIV_N_W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, divisor};
  assign fits     = !diff[ssr_pkg::DIV_D_W+1];
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= steps;
      done <= 1'b0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == 1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[ssr_pkg::DIV_D_W-1:0] : rem_sh[ssr_pkg::DIV_D_W-1:0];
      dq  <= {dq[ssr_pkg::DIV_N_W-2:0], fits};
    end
  end

endmodule

// ----- src/ssr_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_dp
// Ramp datapath: settings, move state, increment and period arithmetic
// ----------------------------------------------------------------------------
module ssr_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [1:0]                         cfg_index,
  input  logic [ssr_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               req_type,
  input  logic signed [ssr_pkg::STEP_W-1:0]  move_steps,
  input  ssr_pkg::ctrl_cmd_t                 cmd,
  output ssr_pkg::ctrl_sts_t                 sts,
  output logic [ssr_pkg::PERIOD_W-1:0]       step_period_us,
  output logic signed [ssr_pkg::SPEED_W-1:0] current_speed,
  output logic [1:0]                         ramp_phase
);

  logic [ssr_pkg::CFG_W-1:0]          min_speed;
  logic [ssr_pkg::CFG_W-1:0]          max_speed;
  logic [ssr_pkg::CFG_W-1:0]          accel_step;
  logic [ssr_pkg::CFG_W-1:0]          nonlinear_divisor;

  logic signed [ssr_pkg::SPEED_W-1:0] speed_now;
  logic [ssr_pkg::PERIOD_W-1:0]       period_now;
  logic [ssr_pkg::STEP_W-1:0]         step_count;
  logic [ssr_pkg::COUNT_W-1:0]        total_steps;
  logic [ssr_pkg::COUNT_W-1:0]        half_steps;
  logic [ssr_pkg::STEP_W-1:0]         decel_start;
  logic                               accel_done;
  ssr_pkg::kind_t                     kind;
  logic [1:0]                         phase;

  ssr_pkg::kind_t                     kind_now;
  logic [ssr_pkg::STEP_W-1:0]         raw;
  logic [ssr_pkg::STEP_W-1:0]         mag_raw;
  logic [ssr_pkg::COUNT_W-1:0]        mag;
  logic [ssr_pkg::STEP_W-1:0]         step_inc;
  logic [ssr_pkg::STEP_W-1:0]         total_ext;

  logic [ssr_pkg::DIV_N_W-1:0]        div_dividend;
  logic [ssr_pkg::DIV_D_W-1:0]        div_divisor;
  logic [ssr_pkg::DIV_CNT_W-1:0]      div_steps;
  logic                               div_done;
  logic [ssr_pkg::DIV_N_W-1:0]        div_q;
  logic [ssr_pkg::DIV_D_W-1:0]        per_src;

  logic [ssr_pkg::DIV_N_W-1:0]        inc_q;
  logic [ssr_pkg::DIV_N_W:0]          inc;
  logic signed [ssr_pkg::SUM_W-1:0]   spd_ext;
  logic signed [ssr_pkg::SUM_W-1:0]   inc_ext;
  logic signed [ssr_pkg::SUM_W-1:0]   sum;
  logic signed [ssr_pkg::SPEED_W-1:0] speed_sat;

  // settings
  always_ff @(posedge clk) begin
    if (rst) begin
      min_speed         <= ssr_pkg::MIN_SPEED_RST;
      max_speed         <= ssr_pkg::MAX_SPEED_RST;
      accel_step        <= ssr_pkg::ACCEL_RST;
      nonlinear_divisor <= ssr_pkg::NONLIN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ssr_pkg::CFG_MIN_SPEED: min_speed         <= cfg_data;
        ssr_pkg::CFG_MAX_SPEED: max_speed         <= cfg_data;
        ssr_pkg::CFG_ACCEL:     accel_step        <= cfg_data;
        ssr_pkg::CFG_NONLIN:    nonlinear_divisor <= cfg_data;
        default: ;
      endcase
    end
  end

  // decision for the incoming word
  assign total_ext = {1'b0, total_steps};

  always_comb begin
    if (!req_type) begin
      kind_now = ssr_pkg::KIND_START;
    end else if (min_speed == max_speed) begin
      kind_now = ssr_pkg::KIND_EQUAL;
    end else if (!accel_done) begin
      if (speed_now <= $signed({16'd0, max_speed}) && step_count <= {1'b0, half_steps}) begin
        kind_now = ssr_pkg::KIND_ACCEL;
      end else begin
        kind_now = ssr_pkg::KIND_END_ACCEL;
      end
    end else if (step_count >= decel_start) begin
      kind_now = ssr_pkg::KIND_DECEL;
    end else begin
      kind_now = ssr_pkg::KIND_HOLD;
    end
  end

  assign raw      = move_steps;
  assign mag_raw  = raw[ssr_pkg::STEP_W-1] ? (32'd0 - raw) : raw;
  assign mag      = mag_raw[ssr_pkg::STEP_W-1] ? {ssr_pkg::COUNT_W{1'b1}}
                                               : mag_raw[ssr_pkg::COUNT_W-1:0];
  assign step_inc = (step_count == {ssr_pkg::STEP_W{1'b1}}) ? step_count
                                                             : step_count + 32'd1;

  // divider operands
  always_comb begin
    case (kind)
      ssr_pkg::KIND_START:     per_src = {16'd0, min_speed};
      ssr_pkg::KIND_END_ACCEL: per_src = {16'd0, max_speed};
      default:                 per_src = speed_now;
    endcase
  end

  always_comb begin
    if (cmd.div_sel == ssr_pkg::DIV_INC) begin
      div_dividend = 36'(accel_step) * 36'(period_now);
      div_divisor  = {16'd0, nonlinear_divisor};
      div_steps    = ssr_pkg::INC_STEPS;
    end else begin
      div_dividend = {ssr_pkg::US_PER_SEC, 16'd0};
      div_divisor  = per_src;
      div_steps    = ssr_pkg::PER_STEPS;
    end
  end

  ssr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_q)
  );

  // speed update with saturation
  assign inc_q   = (nonlinear_divisor == '0) ? '0 : div_q;
  assign inc     = 37'(accel_step) + 37'(inc_q);
  assign spd_ext = {{8{speed_now[ssr_pkg::SPEED_W-1]}}, speed_now};
  assign inc_ext = {3'b000, inc};
  assign sum     = (kind == ssr_pkg::KIND_DECEL) ? spd_ext - inc_ext : spd_ext + inc_ext;

  always_comb begin
    if (sum > 40'sh007FFFFFFF) begin
      speed_sat = 32'sh7FFFFFFF;
    end else if (sum < 40'shFF80000000) begin
      speed_sat = 32'sh80000000;
    end else begin
      speed_sat = sum[ssr_pkg::SPEED_W-1:0];
    end
  end

  // move state
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_now   <= '0;
      period_now  <= '0;
      step_count  <= '0;
      total_steps <= '0;
      half_steps  <= '0;
      decel_start <= '0;
      accel_done  <= 1'b0;
      kind        <= ssr_pkg::KIND_START;
      phase       <= ssr_pkg::PHASE_ACCEL;
    end else begin
      if (cmd.load_item) begin
        kind <= kind_now;
        case (kind_now)
          ssr_pkg::KIND_START: begin
            total_steps <= mag;
            half_steps  <= mag >> 1;
            step_count  <= '0;
            decel_start <= {1'b0, mag};
            accel_done  <= 1'b0;
            speed_now   <= $signed({16'd0, min_speed});
            phase       <= ssr_pkg::PHASE_ACCEL;
          end
          ssr_pkg::KIND_EQUAL: begin
            phase <= ssr_pkg::PHASE_CRUISE;
          end
          ssr_pkg::KIND_ACCEL: begin
            phase      <= ssr_pkg::PHASE_ACCEL;
            step_count <= step_inc;
          end
          ssr_pkg::KIND_END_ACCEL: begin
            accel_done  <= 1'b1;
            decel_start <= (step_count >= total_ext) ? '0 : total_ext - step_count;
            phase       <= ssr_pkg::PHASE_CRUISE;
            step_count  <= step_inc;
          end
          ssr_pkg::KIND_DECEL: begin
            phase      <= ssr_pkg::PHASE_DECEL;
            step_count <= step_inc;
          end
          default: begin
            phase      <= ssr_pkg::PHASE_CRUISE;
            step_count <= step_inc;
          end
        endcase
      end
      if (cmd.apply_inc) begin
        speed_now <= speed_sat;
      end
      if (cmd.apply_per) begin
        period_now <= (per_src == '0) ? ssr_pkg::US_PER_SEC : div_q[ssr_pkg::PERIOD_W-1:0];
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      step_period_us <= period_now;
      current_speed  <= speed_now;
      ramp_phase     <= phase;
    end
  end

  assign sts.kind_now  = kind_now;
  assign sts.div_done  = div_done;
  assign sts.speed_pos = !speed_now[ssr_pkg::SPEED_W-1] && (speed_now != '0);

endmodule

// ----- src/ssr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_ctrl
// Sequencer of the ramp: accepts a word, runs the divisions, hands out results
// ----------------------------------------------------------------------------
module ssr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               res_valid,
  input  logic               res_stall,
  input  ssr_pkg::ctrl_sts_t sts,
  output ssr_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INC_GO,
    S_INC_WAIT,
    S_INC_APPLY,
    S_SPD_CHK,
    S_PER_GO,
    S_PER_WAIT,
    S_PER_APPLY,
    S_OUT
  } state_t;

  state_t state;
  logic   out_free;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !res_valid || !res_stall;

  always_comb begin
    cmd           = '0;
    cmd.div_sel   = ssr_pkg::DIV_PER;
    case (state)
      S_IDLE:      cmd.load_item = req_valid;
      S_INC_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = ssr_pkg::DIV_INC;
      end
      S_INC_WAIT:  cmd.div_sel   = ssr_pkg::DIV_INC;
      S_INC_APPLY: cmd.apply_inc = 1'b1;
      S_PER_GO:    cmd.div_go    = 1'b1;
      S_PER_APPLY: cmd.apply_per = 1'b1;
      S_OUT:       cmd.load_out  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            case (sts.kind_now)
              ssr_pkg::KIND_START, ssr_pkg::KIND_END_ACCEL: state <= S_PER_GO;
              ssr_pkg::KIND_ACCEL, ssr_pkg::KIND_DECEL:     state <= S_INC_GO;
              default:                                      state <= S_OUT;
            endcase
          end
        end
        S_INC_GO:    state <= S_INC_WAIT;
        S_INC_WAIT: begin
          if (sts.div_done) begin
            state <= S_INC_APPLY;
          end
        end
        S_INC_APPLY: state <= S_SPD_CHK;
        S_SPD_CHK:   state <= sts.speed_pos ? S_PER_GO : S_OUT;
        S_PER_GO:    state <= S_PER_WAIT;
        S_PER_WAIT: begin
          if (sts.div_done) begin
            state <= S_PER_APPLY;
          end
        end
        S_PER_APPLY: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sim/tb_stepper_speed_ramp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_speed_ramp
// Self-checking bench for the stepper speed ramp generator
// ----------------------------------------------------------------------------
// Drives start and tick words with random gaps, stalls the result side at
// random and compares every result word against a cycle-free model of the
// ramp kept in the bench. Directed moves cover ticks before any start, the
// extremes of the step count, equal speeds, zero settings and saturation;
// random moves then run through a series of settings.
// ----------------------------------------------------------------------------
module tb_stepper_speed_ramp;
  import ssr_pkg::*;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_TICK    = 1'b1;
  localparam int   WORDS_TOTAL = 1550;
  localparam int   MAX_WAIT    = 17;
  localparam int   IDLE_LIMIT  = 2000;
  localparam int   REPORT_MAX  = 10;

  typedef struct packed {
    logic [PERIOD_W-1:0]       period;
    logic signed [SPEED_W-1:0] speed;
    logic [1:0]                phase;
  } ramp_out_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;
  logic                       req_valid = 1'b0;
  logic                       req_stall;
  logic                       req_type = 1'b0;
  logic signed [STEP_W-1:0]   move_steps = '0;
  logic                       res_valid;
  logic                       res_stall = 1'b0;
  logic [PERIOD_W-1:0]        step_period_us;
  logic signed [SPEED_W-1:0]  current_speed;
  logic [1:0]                 ramp_phase;

  stepper_speed_ramp DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_type       (req_type),
    .move_steps     (move_steps),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .step_period_us (step_period_us),
    .current_speed  (current_speed),
    .ramp_phase     (ramp_phase)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // ramp state as the block should hold it
  logic [CFG_W-1:0]    min_spd_m;
  logic [CFG_W-1:0]    max_spd_m;
  logic [CFG_W-1:0]    accel_m;
  logic [CFG_W-1:0]    nonlin_m;
  longint              speed_m;
  logic [PERIOD_W-1:0] period_m;
  logic [STEP_W-1:0]   steps_m;
  logic [COUNT_W-1:0]  total_m;
  logic [COUNT_W-1:0]  half_m;
  logic [STEP_W-1:0]   decel_at_m;
  logic                accel_over_m;

  ramp_out_t ramp_out_q[$];
  int        fail_count = 0;
  int        words_sent = 0;
  int        send_n = 0;
  bit        send_burst = 0;
  int        idle_cycles = 0;

  task automatic reset_model();
    min_spd_m    = MIN_SPEED_RST;
    max_spd_m    = MAX_SPEED_RST;
    accel_m      = ACCEL_RST;
    nonlin_m     = NONLIN_RST;
    speed_m      = 0;
    period_m     = '0;
    steps_m      = '0;
    total_m      = '0;
    half_m       = '0;
    decel_at_m   = '0;
    accel_over_m = 1'b0;
  endtask

  function automatic logic [PERIOD_W-1:0] period_for(longint spd);
    longint us;
    us = US_PER_SEC;
    if (spd == 0) return US_PER_SEC;
    return PERIOD_W'(us / spd);
  endfunction

  function automatic longint clamp_speed(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint speed_increment();
    longint a, p, d, inc;
    a = accel_m;
    p = period_m;
    d = nonlin_m;
    inc = a;
    if (d != 0) inc += (a * p) / d;
    return inc;
  endfunction

  function automatic ramp_out_t next_ramp_out(logic kind, logic [STEP_W-1:0] count);
    logic [STEP_W-1:0] mag;
    longint            max_l;
    ramp_out_t         r;
    r.phase = PHASE_CRUISE;
    max_l = max_spd_m;
    if (kind == REQ_START) begin
      mag = count[STEP_W-1] ? -count : count;
      if (mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;
      total_m      = mag[COUNT_W-1:0];
      half_m       = mag[COUNT_W:1];
      steps_m      = '0;
      decel_at_m   = mag;
      accel_over_m = 1'b0;
      speed_m      = min_spd_m;
      period_m     = period_for(min_spd_m);
      r.phase      = PHASE_ACCEL;
    end else if (min_spd_m != max_spd_m) begin
      if (!accel_over_m) begin
        if (speed_m <= max_l && steps_m <= STEP_W'(half_m)) begin
          speed_m = clamp_speed(speed_m + speed_increment());
          if (speed_m > 0) period_m = period_for(speed_m);
          r.phase = PHASE_ACCEL;
        end else begin
          accel_over_m = 1'b1;
          decel_at_m = (steps_m >= STEP_W'(total_m)) ? '0 : STEP_W'(total_m) - steps_m;
          period_m = period_for(max_spd_m);
        end
      end else if (steps_m >= decel_at_m) begin
        speed_m = clamp_speed(speed_m - speed_increment());
        if (speed_m > 0) period_m = period_for(speed_m);
        r.phase = PHASE_DECEL;
      end
      if (steps_m != '1) steps_m = steps_m + 1;
    end
    r.period = period_m;
    r.speed  = speed_m[SPEED_W-1:0];
    return r;
  endfunction

  // one request word; the gap before the next word is taken after acceptance
  task automatic send_word(input logic kind, input logic [STEP_W-1:0] count);
    int gap;
    req_valid  <= 1'b1;
    req_type   <= kind;
    move_steps <= count;
    do @(posedge clk); while (req_stall);
    ramp_out_q.push_back(next_ramp_out(kind, count));
    words_sent++;
    send_n++;
    if (send_n % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (ramp_out_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_SPEED: min_spd_m = val;
      CFG_MAX_SPEED: max_spd_m = val;
      CFG_ACCEL:     accel_m   = val;
      CFG_NONLIN:    nonlin_m  = val;
      default: ;
    endcase
  endtask

  task automatic write_settings(input logic [CFG_W-1:0] lo_spd, hi_spd, acc, nl);
    write_reg(CFG_MIN_SPEED, lo_spd);
    write_reg(CFG_MAX_SPEED, hi_spd);
    write_reg(CFG_ACCEL, acc);
    write_reg(CFG_NONLIN, nl);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_setting();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0:       return 16'd1;
      1:       return 16'hFFFF;
      2, 3:    return CFG_W'($urandom_range(1, 255));
      default: return CFG_W'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic test_ticks_from_reset();
    repeat (3) send_word(REQ_TICK, $urandom);
  endtask

  task automatic test_move_extremes();
    logic signed [STEP_W-1:0] counts [6];
    counts = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, -32'sh7FFF_FFFF, 32'sh8000_0000};
    foreach (counts[i]) begin
      send_word(REQ_START, counts[i]);
      send_word(REQ_TICK, ~counts[i]);
    end
  endtask

  task automatic test_equal_speeds();
    wait_idle();
    write_settings(16'd1234, 16'd1234, 16'd7, 16'd3);
    send_word(REQ_START, 32'sd50);
    repeat (2) send_word(REQ_TICK, $urandom);
  endtask

  task automatic test_degenerate_settings();
    // speed runs into both saturation limits
    wait_idle();
    write_settings(16'd0, 16'd1, 16'hFFFF, 16'd1);
    send_word(REQ_START, 32'sd1);
    repeat (3) send_word(REQ_TICK, $urandom);
    // no increment at all, speed stays at zero
    wait_idle();
    write_settings(16'd0, 16'd5, 16'd0, 16'd0);
    send_word(REQ_START, 32'sd9);
    repeat (2) send_word(REQ_TICK, $urandom);
    // zero cruise speed
    wait_idle();
    write_settings(16'd3, 16'd0, 16'd2, 16'd9);
    send_word(REQ_START, -32'sd2);
    repeat (2) send_word(REQ_TICK, $urandom);
  endtask

  task automatic test_random_moves();
    int                       sel, mag, ticks, next_cfg_at;
    logic signed [STEP_W-1:0] count;
    next_cfg_at = 0;
    while (words_sent < WORDS_TOTAL) begin
      if (words_sent >= next_cfg_at) begin
        wait_idle();
        write_settings(pick_setting(), pick_setting(), pick_setting(), pick_setting());
        next_cfg_at = words_sent + $urandom_range(100, 250);
      end
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        mag = $urandom_range(0, 60);
        ticks = mag + $urandom_range(0, 8);
      end else if (sel < 9) begin
        mag = $urandom_range(61, 400);
        ticks = $urandom_range(20, 120);
      end else begin
        mag = 0;
        ticks = $urandom_range(20, 120);
      end
      if (sel == 9) count = $urandom;
      else count = $urandom_range(0, 1) ? -mag : mag;
      send_word(REQ_START, count);
      repeat (ticks) begin
        if ($urandom_range(0, 39) == 0) send_word(REQ_START, $urandom);
        else send_word(REQ_TICK, $urandom);
      end
    end
  endtask

  // result side: checks each word and stalls at random
  ramp_out_t want;
  int        hold_left = 0;
  int        rcv_n = 0;
  bit        rcv_burst = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (ramp_out_q.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("result word with nothing pending: period %0d speed %0d phase %0d",
                     step_period_us, current_speed, ramp_phase);
          fail_count++;
        end else begin
          want = ramp_out_q.pop_front();
          if (want.period !== step_period_us || want.speed !== current_speed ||
              want.phase !== ramp_phase) begin
            if (fail_count < REPORT_MAX)
              $display("ramp mismatch: want period %0d speed %0d phase %0d, got %0d %0d %0d",
                       want.period, want.speed, want.phase,
                       step_period_us, current_speed, ramp_phase);
            fail_count++;
          end
        end
        rcv_n++;
        if (rcv_n % 40 == 0) rcv_burst = ($urandom_range(0, 3) == 0);
        hold_left = rcv_burst ? 0 : $urandom_range(0, MAX_WAIT);
        res_stall <= (hold_left != 0);
      end else if (res_valid && res_stall) begin
        if (hold_left != 0) hold_left--;
        res_stall <= (hold_left != 0);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("[stepper_speed_ramp] ERROR");
        $finish;
      end
    end
  end

  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_ticks_from_reset();
    test_move_extremes();
    test_equal_speeds();
    test_degenerate_settings();
    test_random_moves();
    wait_idle();
    repeat (20) @(posedge clk);
    fail_count += ramp_out_q.size();
    if (fail_count == 0) begin
      $display("[stepper_speed_ramp] OK");
    end else begin
      $display("[stepper_speed_ramp] ERROR");
    end
    $finish;
  end

endmodule
